// ===== hw/rtl/tkspq_pkg.sv =====
// shared types and constants for the two-key sorted priority queue
// used by tkspq_cell and two_key_sorted_priority_queue_unit; no dependencies
package tkspq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int OCC_W       = 5;

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_REMOVE = 1'b1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic [7:0] sec;
    logic [7:0] pri;
    logic [7:0] id;
  } entry_t;

  // broadcast to every cell of the chain
  typedef struct packed {
    logic   ins;
    logic   rem;
    entry_t din;
  } cell_ctrl_t;

endpackage

// ===== hw/rtl/tkspq_cell.sv =====
// one slot of the sorted chain: holds an entry and shifts with its neighbors
// depends on tkspq_pkg
module tkspq_cell
  import tkspq_pkg::*;
(
  input  logic       clk,
  input  cell_ctrl_t ctrl,
  input  logic       occ,        // slot holds a live entry
  input  logic       tail,       // first free slot
  input  logic       left_after, // left neighbor moves right on insert
  input  entry_t     left_entry,
  input  entry_t     right_entry,
  output entry_t     entry,
  output logic       after       // live entry ordered strictly behind the new one
);

  always_comb begin
    after = 1'b0;
    if (occ) begin
      if (entry.pri != ctrl.din.pri) begin
        after = entry.pri > ctrl.din.pri;
      end else begin
        after = entry.sec > ctrl.din.sec;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.ins) begin
      if (left_after) begin
        entry <= left_entry;
      end else if (after || tail) begin
        entry <= ctrl.din;
      end
    end else if (ctrl.rem) begin
      entry <= right_entry;
    end
  end

endmodule

// ===== hw/rtl/two_key_sorted_priority_queue_unit.sv =====
// top level of the two-key sorted priority queue: a chain of tkspq_cell slots,
// the entry count and the registered result stage; depends on tkspq_pkg
//
// The queue keeps up to QUEUE_DEPTH entries in ascending (primary, secondary)
// key order in a row of cells, slot 0 being the head; equal keys keep arrival
// order. Every cell compares its entry against the incoming keys at once, so an
// insert or a remove completes in the cycle it is accepted and one item is taken
// per clock unless the result register stalls the input. Each item gives exactly
// one result, held in an output register; a new item is taken while that
// register is empty or being read. No clearing pass is needed after reset.
module two_key_sorted_priority_queue_unit
  import tkspq_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,  // item_id[7:0], primary_key[15:8], secondary_key[23:16]
  input  logic        s_tuser,  // mode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,  // out_id[7:0], out_primary[15:8], out_secondary[23:16],
                                // occupancy[28:24], zero[31:29]
  output logic [2:0]  m_tuser   // status[1:0], out_valid[2]
);

  logic [CNT_W-1:0]      count;
  logic [CNT_W-1:0]      count_next;
  cell_ctrl_t            ctrl;
  entry_t                entries [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] after;
  logic                  accept;
  logic                  full;
  logic                  empty;
  status_t               status_next;

  logic [1:0]       status;
  logic             out_valid;
  entry_t           out_entry;
  logic [OCC_W-1:0] occupancy;

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;
  assign full     = count == CNT_W'(QUEUE_DEPTH);
  assign empty    = count == '0;

  assign ctrl.din.id  = s_tdata[7:0];
  assign ctrl.din.pri = s_tdata[15:8];
  assign ctrl.din.sec = s_tdata[23:16];
  assign ctrl.ins     = accept && (s_tuser == MODE_INSERT) && !full;
  assign ctrl.rem     = accept && (s_tuser == MODE_REMOVE) && !empty;

  always_comb begin
    count_next = count;
    if (ctrl.ins) begin
      count_next = count + CNT_W'(1);
    end else if (ctrl.rem) begin
      count_next = count - CNT_W'(1);
    end
    if (s_tuser == MODE_INSERT) begin
      status_next = full ? ST_FULL : ST_OK;
    end else begin
      status_next = empty ? ST_EMPTY : ST_OK;
    end
  end

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic   left_after;
    entry_t left_entry;
    entry_t right_entry;

    if (i == 0) begin : g_head
      assign left_after = 1'b0;
      assign left_entry = '0;
    end else begin : g_body
      assign left_after = after[i-1];
      assign left_entry = entries[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign right_entry = '0;
    end else begin : g_inner
      assign right_entry = entries[i+1];
    end

    tkspq_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .occ         (count > CNT_W'(i)),
      .tail        (count == CNT_W'(i)),
      .left_after  (left_after),
      .left_entry  (left_entry),
      .right_entry (right_entry),
      .entry       (entries[i]),
      .after       (after[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      count <= count_next;
      if (accept) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      status    <= status_next;
      out_valid <= ctrl.rem;
      out_entry <= ctrl.rem ? entries[0] : '0;
      occupancy <= OCC_W'(count_next);
    end
  end

  assign m_tdata = {3'b000, occupancy, out_entry.sec, out_entry.pri, out_entry.id};
  assign m_tuser = {out_valid, status};

  a_count_bound : assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(QUEUE_DEPTH))
    else $error("entry count beyond queue depth");

  a_ins_count : assert property (@(posedge clk) disable iff (rst)
    ctrl.ins |=> count == $past(count) + CNT_W'(1))
    else $error("insert did not grow the count");

  a_rem_count : assert property (@(posedge clk) disable iff (rst)
    ctrl.rem |=> count == $past(count) - CNT_W'(1))
    else $error("remove did not shrink the count");

  a_head_sorted : assert property (@(posedge clk) disable iff (rst)
    count >= CNT_W'(2) |->
      (entries[0].pri < entries[1].pri) ||
      (entries[0].pri == entries[1].pri && entries[0].sec <= entries[1].sec))
    else $error("head entry out of order");

  a_stall_holds : assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid)
    else $error("input stalled with no pending result");

endmodule
